[src/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator package
// Sizes, codes and shared types for the block allocator and its word search.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned MaxBlocks   = 65536;
  localparam int unsigned MapWordBits = 32;
  localparam int unsigned MapWords    = MaxBlocks / MapWordBits;
  localparam int unsigned AddrW       = $clog2(MapWords);
  localparam int unsigned BitW        = $clog2(MapWordBits);
  localparam int unsigned BlkW        = 16;
  localparam int unsigned CntW        = 17;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [CntW-1:0] CountCap   = CntW'(MaxBlocks);
  localparam logic [CntW-1:0] ScanLimit  = CntW'(65536);
  localparam logic [CntW-1:0] TotalReset = CntW'(65536);

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_MARK  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_NO_FREE = 2'd1,
    STATUS_IGNORED = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DATA_START   = 2'd0,
    CFG_TOTAL_BLOCKS = 2'd1,
    CFG_INITIAL_FREE = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [MapWordBits-1:0] word;
    logic                   lo_en;
    logic [BitW-1:0]        lo_bit;
    logic                   hi_en;
    logic [BitW-1:0]        hi_bit;
  } search_req_t;

  typedef struct packed {
    logic            found;
    logic [BitW-1:0] index;
  } search_res_t;

endpackage

[src/bfa_word_search.sv]
// ----------------------------------------------------------------------------
// Bitmap word search
// Finds the lowest clear bit of one map word inside the permitted bit window.
// ----------------------------------------------------------------------------
module bfa_word_search (
  input  bfa_pkg::search_req_t req_i,
  output bfa_pkg::search_res_t res_o
);

  logic [bfa_pkg::MapWordBits-1:0] lo_mask;
  logic [bfa_pkg::MapWordBits-1:0] hi_mask;
  logic [bfa_pkg::MapWordBits-1:0] cand;

  always_comb begin
    lo_mask = '1;
    hi_mask = '1;
    if (req_i.lo_en) begin
      lo_mask = {bfa_pkg::MapWordBits{1'b1}} << req_i.lo_bit;
    end
    if (req_i.hi_en) begin
      hi_mask = ~({bfa_pkg::MapWordBits{1'b1}} << req_i.hi_bit);
    end
    cand = ~req_i.word & lo_mask & hi_mask;
  end

  always_comb begin
    res_o.found = 1'b0;
    res_o.index = '0;
    for (int i = bfa_pkg::MapWordBits - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res_o.found = 1'b1;
        res_o.index = bfa_pkg::BitW'(i);
      end
    end
  end

endmodule

[src/bitmap_first_fit_allocator_unit.sv]
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator
// Keeps a used-block bitmap and a free-block count; allocates, frees and marks.
// ----------------------------------------------------------------------------
// After reset the bitmap is cleared one word a cycle, all 2048 words, with busy high.
// An allocate request reads and evaluates one map word at a time, in ST_READ and
// ST_EVAL, as the map memory has a single read port with registered read data.
// Free and mark requests take one read-modify-write, in ST_READ and ST_EVAL.
// Ignored and no-op requests, and scans over an empty range, answer in the cycle after they are accepted.
// Each result is shown for one cycle on done_o; the receiver cannot stall it.
module bitmap_first_fit_allocator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   func_i,
  input  logic [bfa_pkg::BlkW-1:0]     block_number_i,
  output logic                         done_o,
  output logic [bfa_pkg::BlkW-1:0]     granted_block_o,
  output logic [1:0]                   status_o,
  output logic [bfa_pkg::CntW-1:0]     free_left_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bfa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bfa_pkg::CntW-1:0]     cfg_data_i
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EVAL  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [bfa_pkg::MapWordBits-1:0] mem_q [bfa_pkg::MapWords];
  logic [bfa_pkg::MapWordBits-1:0] rdata_q;
  logic                            mem_we;
  logic [bfa_pkg::AddrW-1:0]       mem_waddr;
  logic [bfa_pkg::MapWordBits-1:0] mem_wdata;

  logic [bfa_pkg::AddrW-1:0] clr_addr_q, clr_addr_d;
  logic [bfa_pkg::AddrW-1:0] word_q, word_d;
  logic [bfa_pkg::BitW-1:0]  bit_q, bit_d;
  bfa_pkg::func_e            op_q, op_d;

  logic [bfa_pkg::BlkW-1:0] data_start_q;
  logic [bfa_pkg::CntW-1:0] total_blocks_q;
  logic [bfa_pkg::CntW-1:0] free_count_q, free_count_d;

  logic                     done_q, done_d;
  logic [bfa_pkg::BlkW-1:0] granted_q, granted_d;
  bfa_pkg::status_e         status_q, status_d;

  logic [bfa_pkg::BlkW-1:0] scan_begin;
  logic [bfa_pkg::CntW-1:0] scan_end;
  logic [bfa_pkg::CntW-1:0] scan_end_m1;
  logic [bfa_pkg::AddrW-1:0] first_word;
  logic [bfa_pkg::AddrW-1:0] last_word;

  bfa_pkg::search_req_t srch_req;
  bfa_pkg::search_res_t srch_res;

  logic [bfa_pkg::MapWordBits-1:0] bit_sel;
  logic                            accept;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign scan_begin  = (data_start_q == '0) ? bfa_pkg::BlkW'(1) : data_start_q;
  assign scan_end    = (total_blocks_q > bfa_pkg::ScanLimit) ? bfa_pkg::ScanLimit
                                                             : total_blocks_q;
  assign scan_end_m1 = scan_end - bfa_pkg::CntW'(1);
  assign first_word  = scan_begin[bfa_pkg::BlkW-1:bfa_pkg::BitW];
  assign last_word   = scan_end_m1[bfa_pkg::BlkW-1:bfa_pkg::BitW];

  always_comb begin
    srch_req.word   = rdata_q;
    srch_req.lo_en  = (word_q == first_word);
    srch_req.lo_bit = scan_begin[bfa_pkg::BitW-1:0];
    srch_req.hi_en  = (word_q == last_word) && (scan_end[bfa_pkg::BitW-1:0] != '0);
    srch_req.hi_bit = scan_end[bfa_pkg::BitW-1:0];
  end

  bfa_word_search u_search (
    .req_i (srch_req),
    .res_o (srch_res)
  );

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    word_d       = word_q;
    bit_d        = bit_q;
    op_d         = op_q;
    free_count_d = free_count_q;
    done_d       = 1'b0;
    granted_d    = granted_q;
    status_d     = status_q;
    mem_we       = 1'b0;
    mem_waddr    = word_q;
    mem_wdata    = rdata_q;
    bit_sel      = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + bfa_pkg::AddrW'(1);
        if (clr_addr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_d      = bfa_pkg::func_e'(func_i);
          word_d    = block_number_i[bfa_pkg::BlkW-1:bfa_pkg::BitW];
          bit_d     = block_number_i[bfa_pkg::BitW-1:0];
          granted_d = '0;
          status_d  = bfa_pkg::STATUS_DONE;
          unique case (bfa_pkg::func_e'(func_i))
            bfa_pkg::FUNC_ALLOC: begin
              if (bfa_pkg::CntW'(scan_begin) >= scan_end) begin
                status_d = bfa_pkg::STATUS_NO_FREE;
                done_d   = 1'b1;
              end else begin
                word_d  = first_word;
                state_d = ST_READ;
              end
            end
            bfa_pkg::FUNC_FREE: begin
              if (block_number_i == '0 ||
                  bfa_pkg::CntW'(block_number_i) >= total_blocks_q) begin
                status_d = bfa_pkg::STATUS_IGNORED;
                done_d   = 1'b1;
              end else begin
                state_d = ST_READ;
              end
            end
            bfa_pkg::FUNC_MARK: begin
              state_d = ST_READ;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (op_q == bfa_pkg::FUNC_ALLOC) begin
          bit_sel = bfa_pkg::MapWordBits'(1) << srch_res.index;
          if (srch_res.found) begin
            mem_we    = 1'b1;
            mem_wdata = rdata_q | bit_sel;
            granted_d = {word_q, srch_res.index};
            if (free_count_q != '0) begin
              free_count_d = free_count_q - bfa_pkg::CntW'(1);
            end
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else if (word_q == last_word) begin
            status_d = bfa_pkg::STATUS_NO_FREE;
            done_d   = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            word_d  = word_q + bfa_pkg::AddrW'(1);
            state_d = ST_READ;
          end
        end else begin
          bit_sel = bfa_pkg::MapWordBits'(1) << bit_q;
          mem_we  = 1'b1;
          if (op_q == bfa_pkg::FUNC_FREE) begin
            mem_wdata = rdata_q & ~bit_sel;
            if (free_count_q < bfa_pkg::CountCap) begin
              free_count_d = free_count_q + bfa_pkg::CntW'(1);
            end
          end else begin
            mem_wdata = rdata_q | bit_sel;
          end
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_valid_i && cfg_index_i == bfa_pkg::CFG_INITIAL_FREE) begin
      free_count_d = (cfg_data_i > bfa_pkg::CountCap) ? bfa_pkg::CountCap : cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[word_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_addr_q     <= '0;
      free_count_q   <= '0;
      data_start_q   <= '0;
      total_blocks_q <= bfa_pkg::TotalReset;
      done_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      free_count_q <= free_count_d;
      done_q       <= done_d;
      if (cfg_valid_i) begin
        unique case (bfa_pkg::cfg_idx_e'(cfg_index_i))
          bfa_pkg::CFG_DATA_START:   data_start_q   <= cfg_data_i[bfa_pkg::BlkW-1:0];
          bfa_pkg::CFG_TOTAL_BLOCKS: total_blocks_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q    <= word_d;
    bit_q     <= bit_d;
    op_q      <= op_d;
    granted_q <= granted_d;
    status_q  <= status_d;
  end

  assign done_o          = done_q;
  assign granted_block_o = granted_q;
  assign status_o        = status_q;
  assign free_left_o     = free_count_q;

endmodule
